// ----- design/clip_stack_rect_clipper_defines.svh -----
// assertion helpers used by the checker of the clip stack
`ifndef CLIP_STACK_RECT_CLIPPER_DEFINES_SVH
`define CLIP_STACK_RECT_CLIPPER_DEFINES_SVH

// property that is off while reset is held
`define CSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that is checked through reset as well
`define CSRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/csrc_pkg.sv -----
`timescale 1ns / 1ps
package csrc_pkg;

  localparam int SURF_MAX = 16384;
  localparam int WIN_W    = 18;

  localparam logic [1:0] CMD_QUERY     = 2'd0;
  localparam logic [1:0] CMD_PUSH      = 2'd1;
  localparam logic [1:0] CMD_POP       = 2'd2;
  localparam logic [1:0] CMD_QUERY_ALT = 2'd3;

  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;

  typedef logic signed [WIN_W-1:0] win_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } rect_t;

  typedef struct packed {
    logic        accepted;
    logic        visible;
    logic [13:0] clipped_x;
    logic [13:0] clipped_y;
    logic [14:0] clipped_w;
    logic [14:0] clipped_h;
    logic [4:0]  stack_depth;
  } result_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic use_target;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_query;
    logic depth_zero;
    logic last_entry;
    logic meet_ok;
  } dp_status_t;

endpackage

// ----- design/csrc_in_if.sv -----
`timescale 1ns / 1ps
interface csrc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;

  modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

// ----- design/csrc_out_if.sv -----
`timescale 1ns / 1ps
interface csrc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        visible;
  logic [13:0] clipped_x;
  logic [13:0] clipped_y;
  logic [14:0] clipped_w;
  logic [14:0] clipped_h;
  logic [4:0]  stack_depth;

  modport source (output valid, accepted, visible, clipped_x, clipped_y, clipped_w,
                  clipped_h, stack_depth, input ready);
  modport sink (input valid, accepted, visible, clipped_x, clipped_y, clipped_w,
                clipped_h, stack_depth, output ready);
endinterface

// ----- design/clip_stack_rect_clipper.sv -----
`timescale 1ns / 1ps
// Scissor-rectangle stack. Commands arrive one at a time on in_ch: push stores a clip
// rectangle in the stack RAM (dropped when full), pop drops the top entry (dropped when
// empty), and query clips the target against the surface and every stacked rectangle
// from the bottom up. A query walks the stacked rectangles through the single read port
// of the stack RAM, which feeds one intersection per cycle, and ends early once the
// window goes empty. The result sits in an output register, so a new command is taken
// while the previous result waits on out_ch. surface_width (address 0) and
// surface_height (address 4) are to be written through the APB port only while the
// block is idle; the block itself does not enforce this. Values above 16384 act as
// 16384.
module clip_stack_rect_clipper #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  csrc_in_if.sink           in_ch,
  csrc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import csrc_pkg::*;

  logic [14:0] surface_width_r, surface_width_nxt;
  logic [14:0] surface_height_r, surface_height_nxt;
  logic        cfg_wr;
  ctrl_cmd_t   cmd;
  dp_status_t  status;
  result_t     result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    surface_width_nxt  = surface_width_r;
    surface_height_nxt = surface_height_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_SURFACE_WIDTH) begin
        surface_width_nxt = pwdata[14:0];
      end else begin
        surface_height_nxt = pwdata[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= 15'd640;
      surface_height_r <= 15'd480;
    end else begin
      surface_width_r  <= surface_width_nxt;
      surface_height_r <= surface_height_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_SURFACE_HEIGHT) ? {17'd0, surface_height_r}
                                                   : {17'd0, surface_width_r};

  csrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  csrc_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .surface_width (surface_width_r),
    .surface_height(surface_height_r),
    .in_command    (in_ch.command),
    .in_rect_x     (in_ch.rect_x),
    .in_rect_y     (in_ch.rect_y),
    .in_rect_w     (in_ch.rect_w),
    .in_rect_h     (in_ch.rect_h),
    .result        (result)
  );

  assign out_ch.accepted    = result.accepted;
  assign out_ch.visible     = result.visible;
  assign out_ch.clipped_x   = result.clipped_x;
  assign out_ch.clipped_y   = result.clipped_y;
  assign out_ch.clipped_w   = result.clipped_w;
  assign out_ch.clipped_h   = result.clipped_h;
  assign out_ch.stack_depth = result.stack_depth;

endmodule

// ----- design/csrc_ram.sv -----
`timescale 1ns / 1ps
module csrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/csrc_ctrl.sv -----
`timescale 1ns / 1ps
module csrc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  csrc_pkg::dp_status_t   status,
  output csrc_pkg::ctrl_cmd_t    cmd
);
  import csrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_TARGET = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.in_is_query) begin
            state_nxt = S_FINISH;
          end else if (status.depth_zero) begin
            state_nxt = S_TARGET;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        // an empty intersection ends the walk early
        if (!status.meet_ok) begin
          state_nxt = S_FINISH;
        end else if (status.last_entry) begin
          state_nxt = S_TARGET;
        end
      end
      S_TARGET: begin
        cmd.use_target = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/csrc_datapath.sv -----
`timescale 1ns / 1ps
module csrc_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csrc_pkg::ctrl_cmd_t  cmd,
  output csrc_pkg::dp_status_t status,
  input  logic [14:0]          surface_width,
  input  logic [14:0]          surface_height,
  input  logic [1:0]           in_command,
  input  logic signed [15:0]   in_rect_x,
  input  logic signed [15:0]   in_rect_y,
  input  logic signed [15:0]   in_rect_w,
  input  logic signed [15:0]   in_rect_h,
  output csrc_pkg::result_t    result
);
  import csrc_pkg::*;

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          acc_r, acc_nxt;
  win_t          l_r, t_r, r_r, b_r;
  win_t          l_nxt, t_nxt, r_nxt, b_nxt;
  rect_t         tgt_r;
  result_t       res_r;

  logic          in_is_query, full, empty, push_ok;
  logic [14:0]   sw_c, sh_c;
  logic [IW-1:0] rd_addr;
  logic [63:0]   rd_word;
  rect_t         op;
  win_t          op_x, op_y, op_xr, op_yb;
  win_t          nl, nt, nr, nb;
  win_t          dw_w, dw_h;
  logic          meet_ok;

  assign in_is_query = in_command inside {CMD_QUERY, CMD_QUERY_ALT};
  assign full        = (depth_r == DW'(STACK_DEPTH));
  assign empty       = (depth_r == '0);
  assign push_ok     = cmd.accept && (in_command == CMD_PUSH) && !full;

  assign sw_c = (surface_width > 15'(SURF_MAX)) ? 15'(SURF_MAX) : surface_width;
  assign sh_c = (surface_height > 15'(SURF_MAX)) ? 15'(SURF_MAX) : surface_height;

  // entry zero is addressed at the transfer so the walk starts at once
  assign rd_addr = cmd.accept ? '0 : idx_r + IW'(1);

  csrc_ram #(
    .WIDTH(64),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push_ok),
    .waddr(depth_r[IW-1:0]),
    .wdata({in_rect_x, in_rect_y, in_rect_w, in_rect_h}),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

  // one intersection of the window with a stacked entry or the target
  assign op    = cmd.use_target ? tgt_r : rect_t'(rd_word);
  assign op_x  = WIN_W'(op.x);
  assign op_y  = WIN_W'(op.y);
  assign op_xr = WIN_W'(op.x) + WIN_W'(op.w);
  assign op_yb = WIN_W'(op.y) + WIN_W'(op.h);
  assign nl    = (op_x > l_r) ? op_x : l_r;
  assign nt    = (op_y > t_r) ? op_y : t_r;
  assign nr    = (op_xr < r_r) ? op_xr : r_r;
  assign nb    = (op_yb < b_r) ? op_yb : b_r;
  assign meet_ok = (nr > nl) && (nb > nt);
  assign dw_w  = nr - nl;
  assign dw_h  = nb - nt;

  always_comb begin
    depth_nxt = depth_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    l_nxt     = l_r;
    t_nxt     = t_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    if (cmd.accept) begin
      idx_nxt = '0;
      l_nxt   = '0;
      t_nxt   = '0;
      r_nxt   = win_t'({3'b000, sw_c});
      b_nxt   = win_t'({3'b000, sh_c});
      case (in_command)
        CMD_PUSH: begin
          acc_nxt = !full;
          if (!full) begin
            depth_nxt = depth_r + DW'(1);
          end
        end
        CMD_POP: begin
          acc_nxt = !empty;
          if (!empty) begin
            depth_nxt = depth_r - DW'(1);
          end
        end
        default: begin
          acc_nxt = 1'b1;
        end
      endcase
    end else if (cmd.step) begin
      idx_nxt = idx_r + IW'(1);
      if (meet_ok) begin
        l_nxt = nl;
        t_nxt = nt;
        r_nxt = nr;
        b_nxt = nb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      idx_r   <= '0;
      acc_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r <= l_nxt;
    t_r <= t_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
    if (cmd.accept) begin
      tgt_r <= {in_rect_x, in_rect_y, in_rect_w, in_rect_h};
    end
    if (cmd.load_out) begin
      res_r.accepted    <= acc_r;
      res_r.stack_depth <= 5'(depth_r);
      // only the target step can report a visible rectangle
      if (cmd.use_target && meet_ok) begin
        res_r.visible   <= 1'b1;
        res_r.clipped_x <= nl[13:0];
        res_r.clipped_y <= nt[13:0];
        res_r.clipped_w <= dw_w[14:0];
        res_r.clipped_h <= dw_h[14:0];
      end else begin
        res_r.visible   <= 1'b0;
        res_r.clipped_x <= '0;
        res_r.clipped_y <= '0;
        res_r.clipped_w <= '0;
        res_r.clipped_h <= '0;
      end
    end
  end

  assign status.in_is_query = in_is_query;
  assign status.depth_zero  = empty;
  assign status.last_entry  = ((DW'(idx_r) + DW'(1)) == depth_r);
  assign status.meet_ok     = meet_ok;
  assign result             = res_r;

endmodule

// ----- design/csrc_checker.sv -----
`timescale 1ns / 1ps
`include "clip_stack_rect_clipper_defines.svh"
module csrc_checker #(
  parameter int STACK_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_visible,
  input logic [13:0] out_clipped_x,
  input logic [13:0] out_clipped_y,
  input logic [14:0] out_clipped_w,
  input logic [14:0] out_clipped_h,
  input logic [4:0]  out_stack_depth
);

  // a result waiting on the sink keeps its contents
  `CSRC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_visible) && $stable(out_clipped_w) && $stable(out_stack_depth), "result changed while stalled")

  // hidden or non-query results carry an all-zero rectangle
  `CSRC_ASSERT(a_hidden_zero, clk, rst_n, out_valid && !out_visible |-> out_clipped_x == 14'd0 && out_clipped_y == 14'd0 && out_clipped_w == 15'd0 && out_clipped_h == 15'd0, "hidden result has a rectangle")

  // a visible rectangle is an accepted query with real extent
  `CSRC_ASSERT(a_visible_size, clk, rst_n, out_valid && out_visible |-> out_accepted && out_clipped_w != 15'd0 && out_clipped_h != 15'd0, "visible result without extent")

  `CSRC_ASSERT(a_depth_bound, clk, rst_n, out_valid |-> (STACK_DEPTH > 31) || (out_stack_depth <= 5'(STACK_DEPTH)), "stack depth beyond capacity")

  `CSRC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind clip_stack_rect_clipper csrc_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_csrc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_accepted   (out_ch.accepted),
  .out_visible    (out_ch.visible),
  .out_clipped_x  (out_ch.clipped_x),
  .out_clipped_y  (out_ch.clipped_y),
  .out_clipped_w  (out_ch.clipped_w),
  .out_clipped_h  (out_ch.clipped_h),
  .out_stack_depth(out_ch.stack_depth)
);
